// ----- design/brpf_pkg.sv -----
// Shared constants and types for the barrier release packet FIFO.
package brpf_pkg;

    localparam int DEPTH  = 256;
    localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int LEN_W  = 16;
    localparam int TAG_W  = 32;
    localparam int BYTE_W = 24;

    localparam logic [BYTE_W-1:0] BYTE_LIMIT_RESET = 24'd10485760;

    typedef enum logic [1:0] {
        KIND_ENQ        = 2'd0,
        KIND_DEQ        = 2'd1,
        KIND_CHECKPOINT = 2'd2,
        KIND_RELEASE    = 2'd3
    } t_kind;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 80;

endpackage

// ----- design/barrier_release_packet_fifo_top.sv -----
// Barrier release packet descriptor FIFO: queue, barrier/throttle control, result register.
// The result of an accepted word is registered in the output register in the cycle after it.
// Throughput: one word per cycle while the output is taken; the head descriptor is prefetched
// from the slot memory into a read register, so a dequeue never waits on the memory read port.
// Reset (synchronous, active low): queue empty, no barrier, throttled, byte limit 10485760.
// Slot memory contents are not cleared; only written slots are ever read out.
module barrier_release_packet_fifo_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [brpf_pkg::BYTE_W-1:0]      i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: pkt_len[15:0], pkt_tag[47:16]
    input  logic [brpf_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: kind[1:0]
    input  logic [1:0]                       s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: rel_tag[31:0], rel_len[47:32], throttled[48], backlog_bytes[72:49], zero pad
    output logic [brpf_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    // tuser: released[0], dropped[1]
    output logic [1:0]                       m_axis_tuser
);
    import brpf_pkg::*;

    logic [TAG_W-1:0]  mem_tag [DEPTH];
    logic [LEN_W-1:0]  mem_len [DEPTH];

    logic [BYTE_W-1:0] r_limit;
    logic [SLOT_W-1:0] r_head, n_head;
    logic [SLOT_W-1:0] r_tail, n_tail;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [BYTE_W-1:0] r_backlog, n_backlog;
    logic              r_bar_valid, n_bar_valid;
    logic [SLOT_W-1:0] r_bar_slot, n_bar_slot;
    logic              r_throttle, n_throttle;

    logic [TAG_W-1:0]  r_rd_tag;
    logic [LEN_W-1:0]  r_rd_len;

    logic              r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [1:0]        r_out_user;

    logic              accept;
    t_kind             kind;
    logic [LEN_W-1:0]  in_len;
    logic [TAG_W-1:0]  in_tag;
    logic              wr_en;
    logic              res_rel;
    logic              res_drop;
    logic [TAG_W-1:0]  res_tag;
    logic [LEN_W-1:0]  res_len;
    logic [BYTE_W:0]   sum_bytes;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        next_slot = (s == SLOT_W'(DEPTH - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign kind          = t_kind'(s_axis_tuser);
    assign in_len        = s_axis_tdata[LEN_W-1:0];
    assign in_tag        = s_axis_tdata[LEN_W +: TAG_W];
    assign sum_bytes     = {1'b0, r_backlog} + (BYTE_W+1)'(in_len);

    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_backlog   = r_backlog;
        n_bar_valid = r_bar_valid;
        n_bar_slot  = r_bar_slot;
        n_throttle  = r_throttle;
        wr_en       = 1'b0;
        res_rel     = 1'b0;
        res_drop    = 1'b0;
        res_tag     = '0;
        res_len     = '0;
        if (accept) begin
            case (kind)
                KIND_ENQ: begin
                    if (r_count < CNT_W'(DEPTH) && sum_bytes <= {1'b0, r_limit}) begin
                        if (!r_bar_valid) begin
                            n_bar_valid = 1'b1;
                            n_bar_slot  = r_tail;
                        end
                        wr_en     = 1'b1;
                        n_tail    = next_slot(r_tail);
                        n_count   = r_count + CNT_W'(1);
                        n_backlog = sum_bytes[BYTE_W-1:0];
                    end else begin
                        res_drop = 1'b1;
                    end
                end
                KIND_DEQ: begin
                    if (!r_throttle && r_count != '0) begin
                        // head is the barrier: hold it and throttle
                        if (r_bar_valid && r_head == r_bar_slot) begin
                            n_throttle = 1'b1;
                        end else begin
                            res_rel   = 1'b1;
                            res_tag   = r_rd_tag;
                            res_len   = r_rd_len;
                            n_head    = next_slot(r_head);
                            n_count   = r_count - CNT_W'(1);
                            n_backlog = r_backlog - BYTE_W'(r_rd_len);
                        end
                    end
                end
                KIND_CHECKPOINT: begin
                    n_bar_valid = 1'b0;
                end
                KIND_RELEASE: begin
                    n_throttle = 1'b0;
                end
                default: begin
                    n_throttle = r_throttle;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit     <= BYTE_LIMIT_RESET;
            r_head      <= '0;
            r_tail      <= '0;
            r_count     <= '0;
            r_backlog   <= '0;
            r_bar_valid <= 1'b0;
            r_bar_slot  <= '0;
            r_throttle  <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_backlog   <= n_backlog;
            r_bar_valid <= n_bar_valid;
            r_bar_slot  <= n_bar_slot;
            r_throttle  <= n_throttle;
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= {7'd0, n_backlog, n_throttle, res_len, res_tag};
            r_out_user <= {res_drop, res_rel};
        end
    end

    // slot memory; read register always tracks the entry at the next head,
    // with a bypass when that slot is written in the same cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_tag[r_tail] <= in_tag;
            mem_len[r_tail] <= in_len;
        end
        if (wr_en && r_tail == n_head) begin
            r_rd_tag <= in_tag;
            r_rd_len <= in_len;
        end else begin
            r_rd_tag <= mem_tag[n_head];
            r_rd_len <= mem_len[n_head];
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_empty_no_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 |-> r_backlog == '0)
        else $error("bytes queued with no entries");

    a_rel_drop_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("result both released and dropped");

    a_rel_unthrottled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && res_rel |=> !r_throttle && !m_axis_tdata[48])
        else $error("packet released while throttled");

    a_ring_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == '0 || r_count == CNT_W'(DEPTH) |-> r_head == r_tail)
        else $error("head and tail disagree with entry count");

endmodule

// ----- sim/brpf_checker.sv -----
// Checker for the barrier release packet FIFO: predicts every output word and compares it.
`timescale 1ns / 1ps

module brpf_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [brpf_pkg::BYTE_W-1:0]     i_cfg_wdata,
    input  logic                            i_s_tvalid,
    input  logic                            i_s_tready,
    input  logic [brpf_pkg::IN_DATA_W-1:0]  i_s_tdata,
    input  logic [1:0]                      i_s_tuser,
    input  logic                            i_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [brpf_pkg::OUT_DATA_W-1:0] i_m_tdata,
    input  logic [1:0]                      i_m_tuser,
    output int                              o_fail_count,
    output int                              o_pending
);
    import brpf_pkg::*;

    typedef struct packed {
        logic              released;
        logic [TAG_W-1:0]  tag;
        logic [LEN_W-1:0]  len;
        logic              dropped;
        logic              throttled;
        logic [BYTE_W-1:0] backlog;
    } t_fifo_result;

    // predicted queue state
    logic [TAG_W-1:0]  tag_mem [DEPTH];
    logic [LEN_W-1:0]  len_mem [DEPTH];
    logic [SLOT_W-1:0] head_slot;
    logic [SLOT_W-1:0] tail_slot;
    logic [SLOT_W-1:0] barrier_slot;
    logic [CNT_W-1:0]  entry_count;
    logic [BYTE_W-1:0] backlog;
    logic [BYTE_W-1:0] byte_limit;
    logic              barrier_set;
    logic              throttle;

    t_fifo_result expected_results [$];
    int           mismatch_count = 0;

    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(DEPTH - 1)) ? '0 : s + SLOT_W'(1);
    endfunction

    function automatic t_fifo_result step_fifo(input t_kind kind, input logic [LEN_W-1:0] len,
                                               input logic [TAG_W-1:0] tag);
        t_fifo_result r;
        r = '0;
        case (kind)
            KIND_ENQ: begin
                if (entry_count < CNT_W'(DEPTH) &&
                    ({1'b0, backlog} + (BYTE_W+1)'(len)) <= {1'b0, byte_limit}) begin
                    if (!barrier_set) begin
                        barrier_set  = 1'b1;
                        barrier_slot = tail_slot;
                    end
                    tag_mem[tail_slot] = tag;
                    len_mem[tail_slot] = len;
                    tail_slot   = next_slot(tail_slot);
                    entry_count = entry_count + CNT_W'(1);
                    backlog     = backlog + BYTE_W'(len);
                end else begin
                    r.dropped = 1'b1;
                end
            end
            KIND_DEQ: begin
                if (!throttle && entry_count != '0) begin
                    // head sits on the barrier: stop instead of popping
                    if (barrier_set && head_slot == barrier_slot) begin
                        throttle = 1'b1;
                    end else begin
                        r.released  = 1'b1;
                        r.tag       = tag_mem[head_slot];
                        r.len       = len_mem[head_slot];
                        head_slot   = next_slot(head_slot);
                        entry_count = entry_count - CNT_W'(1);
                        backlog     = backlog - BYTE_W'(r.len);
                    end
                end
            end
            KIND_CHECKPOINT: barrier_set = 1'b0;
            default:         throttle = 1'b0;
        endcase
        r.throttled = throttle;
        r.backlog   = backlog;
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_fifo_result got;
        t_fifo_result want;
        if (!i_rst_n) begin
            head_slot    = '0;
            tail_slot    = '0;
            barrier_slot = '0;
            entry_count  = '0;
            backlog      = '0;
            byte_limit   = BYTE_LIMIT_RESET;
            barrier_set  = 1'b0;
            throttle     = 1'b1;
            expected_results.delete();
        end else begin
            if (i_cfg_we)
                byte_limit = i_cfg_wdata;
            // compare first: a word leaving now belongs to an earlier input word
            if (i_m_tvalid && i_m_tready) begin
                got.released  = i_m_tuser[0];
                got.dropped   = i_m_tuser[1];
                got.tag       = i_m_tdata[31:0];
                got.len       = i_m_tdata[47:32];
                got.throttled = i_m_tdata[48];
                got.backlog   = i_m_tdata[72:49];
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display({"unexpected output word: ",
                                  "rel=%0d tag=%h len=%h drop=%0d thr=%0d bl=%0d"},
                                 got.released, got.tag, got.len, got.dropped, got.throttled,
                                 got.backlog);
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"mismatch: exp rel=%0d tag=%h len=%h drop=%0d thr=%0d bl=%0d",
                                      " | got rel=%0d tag=%h len=%h drop=%0d thr=%0d bl=%0d"},
                                     want.released, want.tag, want.len, want.dropped,
                                     want.throttled, want.backlog, got.released, got.tag,
                                     got.len, got.dropped, got.throttled, got.backlog);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                expected_results.push_back(step_fifo(t_kind'(i_s_tuser), i_s_tdata[15:0],
                                                     i_s_tdata[47:16]));
        end
        o_fail_count = mismatch_count;
        o_pending    = expected_results.size();
    end

endmodule

// ----- sim/tb_top.sv -----
// Testbench top for the barrier release packet FIFO: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
    import brpf_pkg::*;

    localparam int HOLD_CYCLES = 300;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [BYTE_W-1:0]     i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [1:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic [1:0]            m_axis_tuser;

    int fail_count;
    int pending;
    int send_idle_pct = 33;
    int recv_idle_pct = 46;
    int words_sent    = 0;
    bit hold_req      = 1'b0;

    always #2 i_clk = ~i_clk;

    barrier_release_packet_fifo_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    brpf_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    // receiver: random backpressure, plus one long hold-off on request
    initial begin
        bit hold_done;
        hold_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !hold_done) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_done = 1'b1;
            end
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_word(input t_kind kind, input logic [LEN_W-1:0] len,
                             input logic [TAG_W-1:0] tag);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {tag, len};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        words_sent++;
    endtask

    task automatic drain;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [BYTE_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    function automatic logic [LEN_W-1:0] pick_len();
        int r;
        r = $urandom_range(99);
        if (r < 10) return '0;
        if (r < 20) return '1;
        if (r < 60) return LEN_W'($urandom_range(1, 255));
        return LEN_W'($urandom);
    endfunction

    task automatic traffic_word(input bit enq);
        if (enq) push_word(KIND_ENQ, pick_len(), $urandom);
        else     push_word(KIND_DEQ, LEN_W'($urandom), $urandom);
    endtask

    task automatic run_random(input int n);
        int target;
        int r;
        target = words_sent + n;
        while (words_sent < target) begin
            r = $urandom_range(99);
            if (r < 50) begin
                repeat ($urandom_range(1, 12)) traffic_word($urandom_range(99) < 55);
            end else if (r < 65) begin
                // open the barrier and let traffic drain
                push_word(KIND_CHECKPOINT, LEN_W'($urandom), $urandom);
                push_word(KIND_RELEASE, LEN_W'($urandom), $urandom);
                repeat ($urandom_range(1, 20)) traffic_word(1'b0);
            end else if (r < 72) begin
                push_word(KIND_RELEASE, LEN_W'($urandom), $urandom);
                repeat ($urandom_range(1, 8)) traffic_word(1'b0);
            end else if (r < 85) begin
                repeat ($urandom_range(10, 40)) traffic_word(1'b1);
            end else begin
                repeat ($urandom_range(1, 4))
                    push_word(t_kind'($urandom_range(3)), LEN_W'($urandom), $urandom);
            end
        end
    endtask

    initial begin
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset limit, starts throttled
        push_word(KIND_DEQ, 16'h0000, 32'h0000_0000);
        push_word(KIND_RELEASE, 16'h0000, 32'h0000_0000);
        push_word(KIND_DEQ, 16'hFFFF, 32'hFFFF_FFFF);
        push_word(KIND_ENQ, 16'h0000, 32'h0000_0000);
        push_word(KIND_ENQ, 16'hFFFF, 32'hFFFF_FFFF);
        push_word(KIND_ENQ, 16'h1234, 32'hA5A5_A5A5);
        push_word(KIND_DEQ, 16'h0000, 32'h0000_0000);     // head is the barrier
        push_word(KIND_DEQ, 16'h0000, 32'h0000_0000);     // throttled
        push_word(KIND_RELEASE, 16'hFFFF, 32'hFFFF_FFFF);
        push_word(KIND_DEQ, 16'h5555, 32'h5555_5555);     // barrier still set
        push_word(KIND_CHECKPOINT, 16'hFFFF, 32'hFFFF_FFFF);
        push_word(KIND_CHECKPOINT, 16'h0000, 32'h0000_0000);
        push_word(KIND_RELEASE, 16'h0000, 32'h0000_0000);
        push_word(KIND_RELEASE, 16'hAAAA, 32'hAAAA_AAAA);
        push_word(KIND_DEQ, 16'h0000, 32'h0000_0000);
        push_word(KIND_ENQ, 16'h0007, 32'h5A5A_5A5A);     // new barrier
        push_word(KIND_DEQ, 16'h0000, 32'h0000_0000);
        push_word(KIND_DEQ, 16'h0000, 32'h0000_0000);
        push_word(KIND_DEQ, 16'h0000, 32'h0000_0000);
        push_word(KIND_CHECKPOINT, 16'h0000, 32'h0000_0000);
        push_word(KIND_RELEASE, 16'h0000, 32'h0000_0000);
        push_word(KIND_DEQ, 16'h0000, 32'h0000_0000);
        push_word(KIND_DEQ, 16'h0000, 32'h0000_0000);     // empty
        drain();

        // zero limit: only empty packets fit
        write_limit('0);
        push_word(KIND_ENQ, 16'h0000, 32'h1357_9BDF);
        push_word(KIND_ENQ, 16'h0001, 32'h2468_ACE0);
        push_word(KIND_CHECKPOINT, 16'h0000, 32'h0000_0000);
        push_word(KIND_DEQ, 16'h0000, 32'h0000_0000);
        drain();

        // phase 0: max limit, long hold-off, and the queue fills past full
        write_limit('1);
        hold_req = 1'b1;
        repeat (270) push_word(KIND_ENQ, LEN_W'($urandom_range(0, 64)), $urandom);
        run_random(120);
        drain();

        send_idle_pct = 46;
        recv_idle_pct = 33;
        write_limit(BYTE_W'(300000));
        run_random(120);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_limit(BYTE_W'($urandom_range(1000000, 16000000)));
        run_random(120);
        drain();

        repeat (8) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
